/* sv/bitmap_tile_planar_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter: assertion macros
// Shared property templates for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TILE_PLANAR_CONVERTER_CORE_DEFINES_SVH
`define BITMAP_TILE_PLANAR_CONVERTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter: shared package
// Payload types, request codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // Default bitmap RAM size in bytes.
    localparam int BTPC_BITMAP_BYTES = 262144;
    // The character buffer is fixed at 2 KB.
    localparam int BTPC_BUFFER_BYTES = 2048;
    localparam int BTPC_BUF_AW       = $clog2(BTPC_BUFFER_BYTES);

    // Request codes of an input transaction.
    typedef enum logic [1:0] {
        REQ_BITMAP_WR = 2'd0,
        REQ_CONVERT   = 2'd1,
        REQ_BUFFER_WR = 2'd2,
        REQ_NONE      = 2'd3
    } req_type_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEPTH_CODE    = 3'd0;
    localparam logic [2:0] CFG_WIDTH_CODE    = 3'd1;
    localparam logic [2:0] CFG_SOURCE_BASE   = 3'd2;
    localparam logic [2:0] CFG_BUFFER_BASE   = 3'd3;
    localparam logic [2:0] CFG_BITMAP_MASK   = 3'd4;
    localparam logic [2:0] CFG_HOST_WE       = 3'd5;
    localparam logic [2:0] CFG_COPROC_WE     = 3'd6;
    localparam logic [2:0] CFG_PROTECT_SIZE  = 3'd7;

    // Input transaction payload.
    typedef struct packed {
        req_type_t   req_type;
        logic [17:0] address;
        logic [7:0]  write_data;
    } req_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] read_data;
        logic       write_blocked;
    } rsp_t;

    // Effective configuration as seen by the engine.
    typedef struct packed {
        logic [1:0]  depth;        // clamped to 2
        logic [2:0]  wsize;        // clamped to 5
        logic [23:0] source_base;
        logic [15:0] buffer_base;
        logic [17:0] bitmap_mask;
        logic        unprotected;  // either write enable set
        logic [3:0]  protect_size;
    } cfg_t;

endpackage

/* sv/btpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter: configuration registers
// Holds the register file and presents the clamped effective settings.
// ----------------------------------------------------------------------------
module btpc_cfg_regs
    import btpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output cfg_t        cfg
);

    logic [1:0]  depth_code_reg;
    logic [2:0]  width_code_reg;
    logic [23:0] source_base_reg;
    logic [15:0] buffer_base_reg;
    logic [17:0] bitmap_mask_reg;
    logic        host_we_reg;
    logic        coproc_we_reg;
    logic [3:0]  protect_size_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_code_reg   <= '0;
            width_code_reg   <= '0;
            source_base_reg  <= '0;
            buffer_base_reg  <= '0;
            bitmap_mask_reg  <= 18'h3ffff;
            host_we_reg      <= 1'b0;
            coproc_we_reg    <= 1'b0;
            protect_size_reg <= 4'hf;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DEPTH_CODE:   depth_code_reg   <= cfg_data[1:0];
                CFG_WIDTH_CODE:   width_code_reg   <= cfg_data[2:0];
                CFG_SOURCE_BASE:  source_base_reg  <= cfg_data;
                CFG_BUFFER_BASE:  buffer_base_reg  <= cfg_data[15:0];
                CFG_BITMAP_MASK:  bitmap_mask_reg  <= cfg_data[17:0];
                CFG_HOST_WE:      host_we_reg      <= cfg_data[0];
                CFG_COPROC_WE:    coproc_we_reg    <= cfg_data[0];
                CFG_PROTECT_SIZE: protect_size_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Clamp the depth and width codes to their largest meaningful values.
    always_comb
    begin
        cfg.depth        = (depth_code_reg > 2'd2) ? 2'd2 : depth_code_reg;
        cfg.wsize        = (width_code_reg > 3'd5) ? 3'd5 : width_code_reg;
        cfg.source_base  = source_base_reg;
        cfg.buffer_base  = buffer_base_reg;
        cfg.bitmap_mask  = bitmap_mask_reg;
        cfg.unprotected  = host_we_reg | coproc_we_reg;
        cfg.protect_size = protect_size_reg;
    end

endmodule

/* sv/btpc_engine.sv */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter: memory engine
// Owns the bitmap RAM and the character buffer RAM and sequences the
// tile conversion: row fetches from the bitmap overlap plane writes into
// the buffer, one byte per memory per cycle.
// ----------------------------------------------------------------------------
`include "bitmap_tile_planar_converter_core_defines.svh"

module btpc_engine
    import btpc_pkg::*;
#(
    parameter int BITMAP_BYTES = BTPC_BITMAP_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic req_valid,
    input  req_t req,
    output logic ready,
    output logic res_valid,
    input  logic res_ready,
    output rsp_t res
);

    localparam int BM_AW = $clog2(BITMAP_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_CONV,
        ST_BUFRD,
        ST_CAPT,
        ST_RESP
    } state_t;

    typedef logic [7:0][7:0] plane_t;

    // Split one pixel row into bitplanes: plane b, bit 7-x is bit b of pixel x.
    function automatic plane_t make_planes(input logic [63:0] row, input logic [1:0] depth);
        plane_t p;
        p = '0;
        for (int x = 0; x < 8; x++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                unique case (depth)
                    2'd0: p[b][7 - x] = row[x * 8 + b];
                    2'd1: if (b < 4) p[b][7 - x] = row[x * 4 + b];
                    default: if (b < 2) p[b][7 - x] = row[x * 2 + b];
                endcase
            end
        end
        return p;
    endfunction

    logic [7:0] bm_mem [BITMAP_BYTES];
    logic [7:0] buf_mem [BTPC_BUFFER_BYTES];

    state_t               state_reg;
    logic [BTPC_BUF_AW-1:0] clr_cnt_reg;
    logic [BTPC_BUF_AW-1:0] rd_addr_reg;
    logic [17:0]          tile_reg;
    logic [17:0]          row_addr_reg;
    logic [2:0]           fb_reg;
    logic [2:0]           fy_reg;
    logic                 fetch_active_reg;
    logic                 rd_v_reg;
    logic [2:0]           rd_b_reg;
    logic [2:0]           rd_y_reg;
    logic                 rd_last_reg;
    logic [7:0]           row_reg [8];
    plane_t               plane_reg;
    logic [2:0]           wy_reg;
    logic [2:0]           wb_reg;
    logic                 wactive_reg;
    logic [7:0]           res_data_reg;
    logic                 res_blocked_reg;
    logic [7:0]           bm_q_reg;
    logic [7:0]           buf_q_reg;

    logic                 accept;
    logic                 blocked;
    logic [5:0]           cmask;
    logic [5:0]           offs;
    logic [17:0]          diff;
    logic [17:0]          tile;
    logic [17:0]          ty;
    logic [17:0]          tx;
    logic [3:0]           ty_shamt;
    logic [17:0]          start_addr;
    logic [17:0]          row_len;
    logic [2:0]           bpp_m1;
    logic [17:0]          fetch_addr;
    logic                 bm_we;
    logic [17:0]          bm_masked;
    logic [BM_AW-1:0]     bm_idx;
    logic [63:0]          row_vec;
    plane_t               planes;
    logic                 buf_we;
    logic [BTPC_BUF_AW-1:0] buf_addr;
    logic [7:0]           buf_wdata;
    logic [BTPC_BUF_AW-1:0] plane_addr;

    assign ready     = (state_reg == ST_IDLE);
    assign accept    = req_valid && ready;
    assign res_valid = (state_reg == ST_RESP);
    assign res.read_data     = res_data_reg;
    assign res.write_blocked = res_blocked_reg;

    // Request decode: protection window, character offset and tile number.
    always_comb
    begin
        blocked = !cfg.unprotected
                  && ({6'b0, req.address} < (24'h000100 << cfg.protect_size));
        cmask   = 6'h3f >> cfg.depth;
        offs    = req.address[5:0] & cmask;
        diff    = (req.address - cfg.source_base[17:0]) & cfg.bitmap_mask;
        tile    = diff >> (3'd6 - {1'b0, cfg.depth});
    end

    // Tile origin in the bitmap and geometry of one character row.
    always_comb
    begin
        ty         = tile_reg >> cfg.wsize;
        tx         = tile_reg & ~(18'h3ffff << cfg.wsize);
        ty_shamt   = 4'd6 + {1'b0, cfg.wsize} - {2'b00, cfg.depth};
        start_addr = cfg.source_base[17:0] + (ty << ty_shamt)
                     + (tx << (2'd3 - cfg.depth));
        row_len    = 18'd1 << (4'd3 + {1'b0, cfg.wsize} - {2'b00, cfg.depth});
        unique case (cfg.depth)
            2'd0:    bpp_m1 = 3'd7;
            2'd1:    bpp_m1 = 3'd3;
            default: bpp_m1 = 3'd1;
        endcase
    end

    // Bitmap port: host writes in idle, row fetches during conversion.
    always_comb
    begin
        fetch_addr = row_addr_reg + {15'b0, fb_reg};
        bm_we      = accept && (req.req_type == REQ_BITMAP_WR) && !blocked;
        bm_masked  = (bm_we ? req.address : fetch_addr) & cfg.bitmap_mask;
        bm_idx     = bm_masked[BM_AW-1:0];
    end

    // Assemble the current row with the byte arriving this cycle, then split it.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            row_vec[i * 8 +: 8] = (rd_b_reg == 3'(i)) ? bm_q_reg : row_reg[i];
        end
        planes = make_planes(row_vec, cfg.depth);
    end

    // Buffer port: clearing pass, plane writes, direct writes, else result read.
    always_comb
    begin
        plane_addr = cfg.buffer_base[BTPC_BUF_AW-1:0]
                     + BTPC_BUF_AW'({wy_reg, 1'b0})
                     + BTPC_BUF_AW'({wb_reg[2:1], 4'b0000})
                     + BTPC_BUF_AW'(wb_reg[0]);
        priority if (state_reg == ST_CLEAR)
        begin
            buf_we    = 1'b1;
            buf_addr  = clr_cnt_reg;
            buf_wdata = 8'h00;
        end
        else if (wactive_reg)
        begin
            buf_we    = 1'b1;
            buf_addr  = plane_addr;
            buf_wdata = plane_reg[wb_reg];
        end
        else if (accept && (req.req_type == REQ_BUFFER_WR))
        begin
            buf_we    = 1'b1;
            buf_addr  = req.address[BTPC_BUF_AW-1:0];
            buf_wdata = req.write_data;
        end
        else
        begin
            buf_we    = 1'b0;
            buf_addr  = rd_addr_reg;
            buf_wdata = 8'h00;
        end
    end

    // Bitmap RAM, one port, registered read.
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_idx] <= req.write_data;
        end
        bm_q_reg <= bm_mem[bm_idx];
    end

    // Character buffer RAM, one port, registered read.
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_addr] <= buf_wdata;
        end
        buf_q_reg <= buf_mem[buf_addr];
    end

    // Sequencer, fetch pipeline and plane writer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            rd_addr_reg      <= '0;
            tile_reg         <= '0;
            row_addr_reg     <= '0;
            fb_reg           <= '0;
            fy_reg           <= '0;
            fetch_active_reg <= 1'b0;
            rd_v_reg         <= 1'b0;
            rd_b_reg         <= '0;
            rd_y_reg         <= '0;
            rd_last_reg      <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                row_reg[i] <= '0;
            end
            plane_reg        <= '0;
            wy_reg           <= '0;
            wb_reg           <= '0;
            wactive_reg      <= 1'b0;
            res_data_reg     <= '0;
            res_blocked_reg  <= 1'b0;
        end
        else
        begin
            // Issue one bitmap fetch per cycle, row by row.
            rd_v_reg <= fetch_active_reg;
            if (fetch_active_reg)
            begin
                rd_b_reg    <= fb_reg;
                rd_y_reg    <= fy_reg;
                rd_last_reg <= (fb_reg == bpp_m1);
                if (fb_reg == bpp_m1)
                begin
                    fb_reg       <= '0;
                    row_addr_reg <= row_addr_reg + row_len;
                    if (fy_reg == 3'd7)
                    begin
                        fetch_active_reg <= 1'b0;
                    end
                    else
                    begin
                        fy_reg <= fy_reg + 3'd1;
                    end
                end
                else
                begin
                    fb_reg <= fb_reg + 3'd1;
                end
            end

            // Collect fetched bytes.
            if (rd_v_reg)
            begin
                row_reg[rd_b_reg] <= bm_q_reg;
            end

            // A complete row loads the plane writer, which then writes out
            // one plane per cycle.
            if (rd_v_reg && rd_last_reg)
            begin
                plane_reg   <= planes;
                wy_reg      <= rd_y_reg;
                wb_reg      <= '0;
                wactive_reg <= 1'b1;
            end
            else if (wactive_reg)
            begin
                wb_reg <= wb_reg + 3'd1;
                if (wb_reg == bpp_m1)
                begin
                    wactive_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_data_reg    <= 8'h00;
                        res_blocked_reg <= (req.req_type == REQ_BITMAP_WR) && blocked;
                        rd_addr_reg     <= cfg.buffer_base[BTPC_BUF_AW-1:0]
                                           + BTPC_BUF_AW'(offs);
                        unique case (req.req_type)
                            REQ_BITMAP_WR:
                            begin
                                state_reg <= ST_RESP;
                            end
                            REQ_CONVERT:
                            begin
                                tile_reg  <= tile;
                                state_reg <= (offs == 6'd0) ? ST_SETUP : ST_BUFRD;
                            end
                            REQ_BUFFER_WR,
                            REQ_NONE:
                            begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_SETUP:
                begin
                    row_addr_reg     <= start_addr;
                    fb_reg           <= '0;
                    fy_reg           <= '0;
                    fetch_active_reg <= 1'b1;
                    state_reg        <= ST_CONV;
                end
                ST_CONV:
                begin
                    if (!fetch_active_reg && !rd_v_reg && !wactive_reg)
                    begin
                        state_reg <= ST_BUFRD;
                    end
                end
                ST_BUFRD:
                begin
                    state_reg <= ST_CAPT;
                end
                ST_CAPT:
                begin
                    res_data_reg <= buf_q_reg;
                    state_reg    <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Every issued fetch returns its byte in the next cycle.
    `BTPC_ASSERT_NEXT(a_fetch_returns, clk, rst_n, fetch_active_reg, rd_v_reg, "fetch lost")
    // Plane writes happen only inside a conversion.
    `BTPC_ASSERT_SAME(a_plane_in_conv, clk, rst_n, wactive_reg, state_reg == ST_CONV,
                      "plane write outside conversion")
    // The result read never starts while conversion traffic is in flight.
    `BTPC_ASSERT_SAME(a_rd_after_conv, clk, rst_n, state_reg == ST_BUFRD,
                      !fetch_active_reg && !rd_v_reg && !wactive_reg,
                      "buffer read overlaps conversion")

endmodule

/* sv/bitmap_tile_planar_converter_core.sv */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter core
// Keeps a bitmap RAM and a 2 KB character buffer and converts bitmap
// characters into planar tiles on conversion reads.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one transaction per request (bitmap byte write,
// conversion read or buffer byte write); the rsp channel returns exactly one
// transaction for each, in order. A transaction moves when valid is high and
// stall is low. Configuration is written through cfg_write_en, cfg_index and
// cfg_data while no request is outstanding.
// Writes and unused codes go straight to the result; a conversion read off a
// character boundary reads one buffer byte first. A conversion read on a
// character boundary fetches 8 rows of bpp bytes from the bitmap RAM, one per
// cycle, while a second unit writes the bpp planes of the previous row into
// the buffer RAM, paced by the single bitmap RAM port. One request is worked
// on at a time.
// After reset the buffer RAM is cleared, one byte per cycle, with req_stall
// high; configuration writes are taken meanwhile.
// The result sits in an output register: while rsp_stall holds it, the next
// request is still taken and worked on, and only its result waits.
// ----------------------------------------------------------------------------
module bitmap_tile_planar_converter_core
    import btpc_pkg::*;
#(
    parameter int BITMAP_BYTES = BTPC_BITMAP_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t cfg;
    logic eng_ready;
    logic res_valid;
    logic res_ready;
    rsp_t res;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    logic load;

    btpc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    btpc_engine #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .ready     (eng_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign req_stall = !eng_ready;

    // Output register: filled when empty or when its transaction leaves.
    assign res_ready      = !rsp_valid_reg || !rsp_stall;
    assign load           = res_valid && res_ready;
    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (load)
            begin
                rsp_reg <= res;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sim/bitmap_tile_planar_converter_core_test.sv */
// ----------------------------------------------------------------------------
// Bitmap tile planar converter: self-checking testbench
// Drives request transactions through the core under several register
// settings and checks each result against a cycle-free model of the bitmap
// RAM, the character buffer and the planar conversion kept in the bench.
// ----------------------------------------------------------------------------
module bitmap_tile_planar_converter_core_test;

    import btpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 120;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_stall;
    req_t        req          = '0;
    logic        rsp_valid;
    logic        rsp_stall    = 1'b0;
    rsp_t        rsp;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [23:0] cfg_data     = '0;

    // Bench copy of the register file.
    logic [1:0]  cfg_depth  = 2'd0;
    logic [2:0]  cfg_width  = 3'd0;
    logic [23:0] cfg_src    = 24'd0;
    logic [15:0] cfg_buf    = 16'd0;
    logic [17:0] cfg_mask   = 18'h3ffff;
    logic        cfg_host   = 1'b0;
    logic        cfg_coproc = 1'b0;
    logic [3:0]  cfg_prot   = 4'd15;

    // Bench copy of the two memories, plus which bitmap bytes hold data.
    logic [7:0]  bitmap_image [0:BTPC_BITMAP_BYTES-1];
    logic [7:0]  buffer_image [0:BTPC_BUFFER_BYTES-1];
    bit          bitmap_known [0:BTPC_BITMAP_BYTES-1];

    req_t        pending_req_q [$];
    rsp_t        owed_rsp_q [$];
    rsp_t        want_rsp;
    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phase_items  = 0;
    bit          calm         = 1'b0;

    bitmap_tile_planar_converter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Effective depth and width after clamping.
    function automatic logic [1:0] eff_depth();
        return (cfg_depth > 2'd2) ? 2'd2 : cfg_depth;
    endfunction

    function automatic logic [2:0] eff_wsize();
        return (cfg_width > 3'd5) ? 3'd5 : cfg_width;
    endfunction

    // Bits per pixel, which is also the number of bytes in one character row.
    function automatic logic [31:0] px_bits();
        return 32'd2 << (2 - eff_depth());
    endfunction

    function automatic logic [31:0] row_stride();
        return (32'd8 << eff_wsize()) >> eff_depth();
    endfunction

    function automatic logic [31:0] char_mask();
        return (32'd1 << (6 - eff_depth())) - 32'd1;
    endfunction

    function automatic logic [17:0] bitmap_slot(input logic [31:0] a);
        return a[17:0] & cfg_mask & 18'(BTPC_BITMAP_BYTES - 1);
    endfunction

    function automatic bit write_refused(input logic [17:0] a);
        if (cfg_host || cfg_coproc)
            return 1'b0;
        return 32'(a) < (32'h100 << cfg_prot);
    endfunction

    // Bitmap address of the first byte of the character that a read selects.
    function automatic logic [31:0] tile_origin(input logic [17:0] a);
        logic [31:0] tile;
        logic [31:0] ty;
        logic [31:0] tx;
        tile = ((32'(a) - 32'(cfg_src)) & 32'(cfg_mask)) >> (6 - eff_depth());
        ty   = tile >> eff_wsize();
        tx   = tile & ((32'd1 << eff_wsize()) - 32'd1);
        return 32'(cfg_src) + ty * 32'd8 * row_stride() + tx * px_bits();
    endfunction

    // Applies one request to the bench memories and returns its result.
    function automatic rsp_t answer_request(input req_t r);
        rsp_t        o;
        logic [31:0] cmask;
        logic [31:0] addr;
        logic [31:0] p;
        logic [63:0] row;
        logic [7:0]  planes [8];
        int          y;
        int          x;
        int          b;
        o = '0;
        case (r.req_type)
            REQ_BITMAP_WR:
            begin
                if (write_refused(r.address))
                    o.write_blocked = 1'b1;
                else
                    bitmap_image[bitmap_slot(r.address)] = r.write_data;
            end
            REQ_CONVERT:
            begin
                cmask = char_mask();
                // A read on a character boundary rebuilds the tile first.
                if ((32'(r.address) & cmask) == 0)
                begin
                    addr = tile_origin(r.address);
                    for (y = 0; y < 8; y++)
                    begin
                        row = '0;
                        for (b = 0; b < px_bits(); b++)
                            row[b*8 +: 8] = bitmap_image[bitmap_slot(addr + b)];
                        addr = addr + row_stride();
                        for (b = 0; b < 8; b++)
                            planes[b] = '0;
                        for (x = 0; x < 8; x++)
                            for (b = 0; b < px_bits(); b++)
                                planes[b][7-x] = row[x*px_bits() + b];
                        for (b = 0; b < px_bits(); b++)
                        begin
                            p = 32'(cfg_buf) + (y << 1) + ((b & 6) << 3) + (b & 1);
                            buffer_image[p[10:0]] = planes[b];
                        end
                    end
                end
                o.read_data = buffer_image[11'(32'(cfg_buf) + (32'(r.address) & cmask))];
            end
            REQ_BUFFER_WR:
                buffer_image[r.address[10:0]] = r.write_data;
            default: ;
        endcase
        return o;
    endfunction

    task automatic queue_request(input req_type_t kind, input logic [17:0] a,
                                 input logic [7:0] d);
        req_t r;
        r.req_type   = kind;
        r.address    = a;
        r.write_data = d;
        pending_req_q.push_back(r);
        if (kind != REQ_NONE)
            phase_items++;
    endtask

    task automatic queue_bitmap_write(input logic [17:0] a, input logic [7:0] d);
        if (!write_refused(a))
            bitmap_known[bitmap_slot(a)] = 1'b1;
        queue_request(REQ_BITMAP_WR, a, d);
    endtask

    // Fills the bytes of one character that hold no data yet, converts it and
    // reads back some of its bytes. Where protection forbids the fill, only a
    // read off the boundary is issued.
    task automatic queue_tile(input logic [17:0] off);
        logic [31:0] origin;
        logic [31:0] cmask;
        logic [17:0] slot;
        logic [17:0] alias_bits;
        logic [17:0] a;
        bit          feasible;
        int          y;
        int          b;
        int          n;
        origin     = tile_origin(off);
        cmask      = char_mask();
        alias_bits = ~cfg_mask;
        feasible   = 1'b1;
        for (y = 0; y < 8; y++)
            for (b = 0; b < px_bits(); b++)
            begin
                slot = bitmap_slot(origin + y * row_stride() + b);
                if (!bitmap_known[slot] && write_refused(slot | alias_bits))
                    feasible = 1'b0;
            end
        if (!feasible)
        begin
            queue_request(REQ_CONVERT, off | 18'd1, 8'($urandom));
            return;
        end
        for (y = 0; y < 8; y++)
            for (b = 0; b < px_bits(); b++)
            begin
                slot = bitmap_slot(origin + y * row_stride() + b);
                if (!bitmap_known[slot])
                begin
                    a = slot | (18'($urandom) & alias_bits);
                    if (write_refused(a))
                        a = slot | alias_bits;
                    queue_bitmap_write(a, 8'($urandom));
                end
            end
        queue_request(REQ_CONVERT, off, 8'($urandom));
        n = $urandom_range(0, 5);
        repeat (n)
            queue_request(REQ_CONVERT, off | 18'($urandom_range(1, cmask)), 8'($urandom));
    endtask

    task automatic queue_random_item();
        logic [17:0] a;
        int          pick;
        a    = 18'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            queue_tile(a & 18'(~char_mask()));
        else if (pick < 68)
            queue_bitmap_write(a, 8'($urandom));
        else if (pick < 80)
            queue_request(REQ_BUFFER_WR, a, 8'($urandom));
        else if (pick < 95)
        begin
            if ((32'(a) & char_mask()) == 0)
                queue_tile(a);
            else
                queue_request(REQ_CONVERT, a, 8'($urandom));
        end
        else
            queue_request(REQ_NONE, a, 8'($urandom));
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [23:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        case (idx)
            CFG_DEPTH_CODE:   cfg_depth  = value[1:0];
            CFG_WIDTH_CODE:   cfg_width  = value[2:0];
            CFG_SOURCE_BASE:  cfg_src    = value;
            CFG_BUFFER_BASE:  cfg_buf    = value[15:0];
            CFG_BITMAP_MASK:  cfg_mask   = value[17:0];
            CFG_HOST_WE:      cfg_host   = value[0];
            CFG_COPROC_WE:    cfg_coproc = value[0];
            CFG_PROTECT_SIZE: cfg_prot   = value[3:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Register settings per phase; the early ones pin the extremes.
    task automatic apply_setting(input int p);
        logic [1:0]  d;
        logic [2:0]  w;
        logic [23:0] s;
        logic [15:0] bb;
        logic [17:0] m;
        logic        h;
        logic        c;
        logic [3:0]  ps;
        d  = 2'($urandom_range(0, 3));
        w  = 3'($urandom_range(0, 7));
        s  = 24'($urandom);
        bb = 16'($urandom);
        m  = (18'd1 << $urandom_range(10, 14)) - 18'd1;
        h  = 1'($urandom);
        c  = 1'($urandom);
        ps = 4'($urandom_range(0, 15));
        case (p)
            0: begin d = 3; w = 7; s = 24'hffffff; bb = 16'hffff; m = 18'h3ffff;
                     h = 1; c = 0; ps = 0; end
            1: begin d = 0; w = 0; s = 0; bb = 0; m = 18'h3ff; h = 1; c = 0; ps = 15; end
            2: begin d = 1; w = 3; m = 18'hfff; h = 0; c = 1; ps = 0; end
            3: begin d = 2; w = 5; s = 24'hffffff; bb = 16'hffff; m = 18'h3ffff;
                     h = 0; c = 0; ps = 0; end
            4: begin d = 0; w = 6; m = 18'h3ff; h = 0; c = 0; ps = 15; end
            5: begin d = 3; w = 7; m = 18'h0; h = 1; c = 1; ps = 4; end
            6: begin d = 1; w = 1; m = 18'h1fff; h = 0; c = 0; ps = 9; end
            7: begin d = 2; w = 2; m = 18'h7fff; h = 1; end
            default: ;
        endcase
        set_register(CFG_DEPTH_CODE, 24'(d));
        set_register(CFG_WIDTH_CODE, 24'(w));
        set_register(CFG_SOURCE_BASE, s);
        set_register(CFG_BUFFER_BASE, 24'(bb));
        set_register(CFG_BITMAP_MASK, 24'(m));
        set_register(CFG_HOST_WE, 24'(h));
        set_register(CFG_COPROC_WE, 24'(c));
        set_register(CFG_PROTECT_SIZE, 24'(ps));
    endtask

    // Holds the sender until every owed result has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_req_q.size() != 0 || req_valid || owed_rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Request driver: presents queued requests with random idle cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                owed_rsp_q.push_back(answer_request(req));
            if (pending_req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28))
            begin
                req       <= pending_req_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result monitor: compares each accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp_q.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected result, read_data %02h write_blocked %0b",
                         $time, rsp.read_data, rsp.write_blocked);
            end
            else
            begin
                want_rsp = owed_rsp_q.pop_front();
                if (rsp.read_data !== want_rsp.read_data)
                begin
                    fault_count++;
                    $display("%0t: read_data expected %02h, actual %02h",
                             $time, want_rsp.read_data, rsp.read_data);
                end
                if (rsp.write_blocked !== want_rsp.write_blocked)
                begin
                    fault_count++;
                    $display("%0t: write_blocked expected %0b, actual %0b",
                             $time, want_rsp.write_blocked, rsp.write_blocked);
                end
            end
        end
        rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus sequence: directed requests, then random phases.
    initial
    begin
        int p;
        foreach (buffer_image[i])
            buffer_image[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: everything protected, full mask, 8 bits per pixel.
        @(negedge clk);
        queue_bitmap_write(18'h00000, 8'hff);
        queue_bitmap_write(18'h3ffff, 8'h00);
        queue_request(REQ_NONE, 18'h3ffff, 8'hff);
        queue_request(REQ_BUFFER_WR, 18'h3ffff, 8'hff);
        queue_request(REQ_BUFFER_WR, 18'h00000, 8'ha5);
        queue_request(REQ_CONVERT, 18'h3ffff, 8'h00);
        queue_request(REQ_CONVERT, 18'h00001, 8'h00);
        drain();

        // Clamped depth and width, top bases, protection lifted.
        apply_setting(0);
        @(negedge clk);
        queue_tile(18'h3fff0);
        drain();

        for (p = 1; p <= 10; p++)
        begin
            apply_setting(p);
            @(negedge clk);
            calm        = (p == 5);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                queue_random_item();
            drain();
        end
        calm = 1'b0;

        repeat (100) @(negedge clk);
        if (fault_count == 0 && owed_rsp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
